@@ hw/rtl/strm_pkg.sv @@
// Shared types and constants for the sparse-table range-minimum unit.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
`default_nettype none

package strm_pkg;

  // Default sizing of the table.
  localparam int DEPTH_DEF      = 1024;
  localparam int LEVELS_DEF     = 11;
  localparam int VALUE_BITS_DEF = 20;

  // Fixed port widths.
  localparam int CMD_W      = 2;
  localparam int VAL_W      = 20;
  localparam int IDX_PORT_W = 10;
  localparam int STAT_W     = 2;
  localparam int MIN_W      = 20;
  localparam int TOTAL_W    = 48;

  // Range lengths reach 2**IDX_PORT_W, so they need one more bit.
  localparam int LEN_W = IDX_PORT_W + 1;
  localparam int K_W   = $clog2(LEN_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_APP0,
    S_APP_LVL,
    S_QRY_A,
    S_QRY_B,
    S_QRY_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    app_setup;
    logic    qry_setup;
    logic    wr_l0;
    logic    app_step;
    logic    rd_a;
    logic    rd_b;
    logic    app_done;
    logic    clear;
    logic    qry_fin;
    logic    emit;
    status_t emit_status;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic q_bad;
    logic more;
    logic more_next;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/strm_ram.sv @@
// Generic single-clock RAM: one write port and one read port with registered read.
// Holds the sparse table. No package dependencies.
`default_nettype none

module strm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/strm_ctrl.sv @@
// Controller state machine for the sparse-table range-minimum unit.
// Depends on strm_pkg; drives the datapath through ctl_t and reads sts_t.
`default_nettype none

module strm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  strm_pkg::sts_t sts,
  output strm_pkg::ctl_t ctl
);

  import strm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_APPEND: begin
            if (sts.full) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = STAT_FULL;
              state_next      = S_IDLE;
            end else begin
              ctl.app_setup = 1'b1;
              state_next    = S_APP0;
            end
          end
          CMD_QUERY: begin
            if (sts.q_bad) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = STAT_BAD_RANGE;
              state_next      = S_IDLE;
            end else begin
              ctl.qry_setup = 1'b1;
              state_next    = S_QRY_A;
            end
          end
          CMD_CLEAR: begin
            ctl.clear       = 1'b1;
            ctl.emit        = 1'b1;
            ctl.emit_status = STAT_OK;
            state_next      = S_IDLE;
          end
          default: begin
            ctl.emit        = 1'b1;
            ctl.emit_status = STAT_OK;
            state_next      = S_IDLE;
          end
        endcase
      end
      S_APP0: begin
        ctl.wr_l0 = 1'b1;
        if (sts.more) begin
          state_next = S_APP_LVL;
        end else begin
          ctl.app_done    = 1'b1;
          ctl.emit        = 1'b1;
          ctl.emit_status = STAT_OK;
          state_next      = S_IDLE;
        end
      end
      S_APP_LVL: begin
        ctl.app_step = 1'b1;
        if (!sts.more_next) begin
          ctl.app_done    = 1'b1;
          ctl.emit        = 1'b1;
          ctl.emit_status = STAT_OK;
          state_next      = S_IDLE;
        end
      end
      S_QRY_A: begin
        ctl.rd_a   = 1'b1;
        state_next = S_QRY_B;
      end
      S_QRY_B: begin
        ctl.rd_b   = 1'b1;
        state_next = S_QRY_FIN;
      end
      S_QRY_FIN: begin
        ctl.qry_fin     = 1'b1;
        ctl.emit        = 1'b1;
        ctl.emit_status = STAT_OK;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/strm_dp.sv @@
// Datapath of the sparse-table range-minimum unit: item registers, table RAM,
// element count, running total and result registers. Depends on strm_pkg and strm_ram.
`default_nettype none

module strm_dp #(
  parameter int DEPTH      = strm_pkg::DEPTH_DEF,
  parameter int LEVELS     = strm_pkg::LEVELS_DEF,
  parameter int VALUE_BITS = strm_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  strm_pkg::ctl_t                   ctl,
  output strm_pkg::sts_t                   sts,
  input  logic [strm_pkg::CMD_W-1:0]       command,
  input  logic [strm_pkg::VAL_W-1:0]       value,
  input  logic [strm_pkg::IDX_PORT_W-1:0]  left_index,
  input  logic [strm_pkg::IDX_PORT_W-1:0]  right_index,
  output logic                             done,
  output logic [strm_pkg::STAT_W-1:0]      status,
  output logic [strm_pkg::MIN_W-1:0]       minimum,
  output logic [strm_pkg::TOTAL_W-1:0]     total
);

  import strm_pkg::*;

  localparam int IDX_W     = $clog2(DEPTH);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int AW        = LVL_W + IDX_W;
  localparam int RAM_DEPTH = LEVELS * (1 << IDX_W);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SP_W      = CNT_W + 1;
  localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Captured item.
  cmd_t                  cmd_r;
  logic [VAL_W-1:0]      val_r;
  logic [IDX_PORT_W-1:0] left_r;
  logic [IDX_PORT_W-1:0] right_r;

  // Persistent state.
  logic [CNT_W-1:0]   count;
  logic [TOTAL_W-1:0] total_r;

  // Append sequencing: level being written, its window start and size.
  logic [LVL_W-1:0]      lvl;
  logic [SP_W-1:0]       start_r;
  logic [SP_W-1:0]       span_r;
  logic                  more_r;
  logic [VALUE_BITS-1:0] carry;

  // Query sequencing.
  logic [K_W-1:0]        k_r;
  logic [VALUE_BITS-1:0] amin;

  logic [STAT_W-1:0] status_r;
  logic [MIN_W-1:0]  minimum_r;
  logic              done_r;

  // Table RAM ports.
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;

  // Combinational helpers.
  logic [VALUE_BITS-1:0] val_m;
  logic [VALUE_BITS-1:0] lvl_min;
  logic [VALUE_BITS-1:0] qry_min;
  logic                  more_next;
  logic [LEN_W-1:0]      len;
  logic [K_W-1:0]        k;
  logic                  q_bad;
  logic [LEN_W-1:0]      rb;
  logic [TOTAL_W:0]      sum;

  strm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (RAM_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign val_m   = VALUE_BITS'(val_r);
  assign lvl_min = (rdata < carry) ? rdata : carry;
  assign qry_min = (amin < rdata) ? amin : rdata;

  // The next level exists when it is below LEVELS and its whole window fits below the new element.
  assign more_next = (int'(lvl) < LEVELS - 1) && (start_r >= span_r);

  // Query decode: length, floor(log2(length)) and range checks.
  always_comb begin
    len = LEN_W'(right_r) - LEN_W'(left_r) + LEN_W'(1);
    k   = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (len[i]) begin
        k = K_W'(i);
      end
    end
    q_bad = (left_r > right_r) || (CMP_W'(right_r) >= CMP_W'(count)) || (int'(k) >= LEVELS);
  end

  assign rb  = LEN_W'(right_r) + LEN_W'(1) - (LEN_W'(1) << k_r);
  assign sum = {1'b0, total_r} + (TOTAL_W + 1)'(qry_min);

  // Table RAM port selection.
  always_comb begin
    we    = ctl.wr_l0 || ctl.app_step;
    waddr = ctl.wr_l0 ? {LVL_W'(0), IDX_W'(count)} : {lvl, IDX_W'(start_r)};
    wdata = ctl.wr_l0 ? val_m : lvl_min;
    re    = (ctl.wr_l0 && more_r) || (ctl.app_step && more_next) || ctl.rd_a || ctl.rd_b;
    raddr = '0;
    if (ctl.wr_l0) begin
      raddr = {LVL_W'(0), IDX_W'(start_r)};
    end else if (ctl.app_step) begin
      raddr = {lvl, IDX_W'(start_r - span_r)};
    end else if (ctl.rd_a) begin
      raddr = {LVL_W'(k_r), IDX_W'(left_r)};
    end else if (ctl.rd_b) begin
      raddr = {LVL_W'(k_r), IDX_W'(rb)};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= cmd_t'(command);
      val_r   <= value;
      left_r  <= left_index;
      right_r <= right_index;
    end
    if (ctl.app_setup) begin
      // Level 1 window of the new element starts one index before it.
      lvl     <= LVL_W'(1);
      span_r  <= SP_W'(2);
      start_r <= SP_W'(count) - SP_W'(1);
      more_r  <= (count != '0);
    end
    if (ctl.wr_l0) begin
      carry <= val_m;
    end
    if (ctl.app_step) begin
      carry <= lvl_min;
      if (more_next) begin
        lvl     <= lvl + LVL_W'(1);
        start_r <= start_r - span_r;
        span_r  <= span_r << 1;
      end
    end
    if (ctl.qry_setup) begin
      k_r <= k;
    end
    if (ctl.rd_b) begin
      amin <= rdata;
    end
    if (ctl.emit) begin
      status_r  <= ctl.emit_status;
      minimum_r <= ctl.qry_fin ? MIN_W'(qry_min) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      total_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= ctl.emit;
      if (ctl.clear) begin
        count   <= '0;
        total_r <= '0;
      end else begin
        if (ctl.app_done) begin
          count <= count + CNT_W'(1);
        end
        if (ctl.qry_fin) begin
          total_r <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end
      end
    end
  end

  assign sts.cmd       = cmd_r;
  assign sts.full      = (count >= CNT_W'(DEPTH));
  assign sts.q_bad     = q_bad;
  assign sts.more      = more_r;
  assign sts.more_next = more_next;

  assign done    = done_r;
  assign status  = status_r;
  assign minimum = minimum_r;
  assign total   = total_r;

endmodule

`default_nettype wire

@@ hw/rtl/sparse_table_range_minimum_unit.sv @@
// Top level of the sparse-table range-minimum unit.
// Depends on strm_pkg, strm_ctrl and strm_dp (which holds strm_ram).
//
// Commands are taken when start is high and busy is low; each command yields
// exactly one result, shown for one cycle with done high, and the receiver
// cannot hold it off. The total port always shows the running total and
// changes only with a result. A new command is not taken until the last one
// has finished. An append fills n = min(LEVELS-1, floor(log2(i+1))) upper
// levels for new index i, one after another after level 0: the table RAM has
// one read port, and each level needs one read of the level below. A valid
// query makes two table reads through the same port, then a compare and a
// saturating add; clear, no-op and rejected commands finish in the decode
// state. The table needs no clearing pass after reset.
`default_nettype none

module sparse_table_range_minimum_unit #(
  parameter int DEPTH      = strm_pkg::DEPTH_DEF,
  parameter int LEVELS     = strm_pkg::LEVELS_DEF,
  parameter int VALUE_BITS = strm_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [strm_pkg::CMD_W-1:0]      command,
  input  logic [strm_pkg::VAL_W-1:0]      value,
  input  logic [strm_pkg::IDX_PORT_W-1:0] left_index,
  input  logic [strm_pkg::IDX_PORT_W-1:0] right_index,
  output logic                            done,
  output logic [strm_pkg::STAT_W-1:0]     status,
  output logic [strm_pkg::MIN_W-1:0]      minimum,
  output logic [strm_pkg::TOTAL_W-1:0]    total
);

  import strm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  strm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  strm_dp #(
    .DEPTH      (DEPTH),
    .LEVELS     (LEVELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (command),
    .value       (value),
    .left_index  (left_index),
    .right_index (right_index),
    .done        (done),
    .status      (status),
    .minimum     (minimum),
    .total       (total)
  );

endmodule

`default_nettype wire

@@ hw/rtl/strm_checker.sv @@
// Port-level checker for the sparse-table range-minimum unit, bound to the top level.
// Depends on strm_pkg for widths and status codes.
`default_nettype none

module strm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [strm_pkg::STAT_W-1:0]     status,
  input logic [strm_pkg::MIN_W-1:0]      minimum,
  input logic [strm_pkg::TOTAL_W-1:0]    total
);

  import strm_pkg::*;

  // An accepted item keeps the unit busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result appears only once the unit has finished its work.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Each item gives one result, so strobes never come in consecutive cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // Rejected commands report a zero minimum.
  a_err_zero_min: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (minimum == '0))
    else $error("nonzero minimum on an error result");

  // The running total moves only when a finishing item produces a result.
  a_total_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(total))
    else $error("total changed while idle");

endmodule

bind sparse_table_range_minimum_unit strm_checker u_strm_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .status  (status),
  .minimum (minimum),
  .total   (total)
);

`default_nettype wire
